@@ hw/rtl/hti_pkg.sv @@
// ----------------------------------------------------------------------------
// hti_pkg: shared constants and types for the hash table insert block
// Table geometry, field widths, tag codes and the slot word layout.
// ----------------------------------------------------------------------------
package hti_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int HASH_W      = 32;
  localparam int SLOT_W      = 10;
  localparam int CAP_W       = 11;

  // Remainder digits resolved per cycle by the modulo unit.
  localparam int DIV_BITS    = 4;
  localparam int DIV_CYC     = HASH_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYC);

  localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(1024);
  localparam logic [CAP_W-1:0]  CAP_MAX     = CAP_W'(TABLE_DEPTH);
  localparam logic [CAP_W-1:0]  CAP_MIN     = CAP_W'(1);

  localparam logic [HASH_W-1:0] TAG_EMPTY   = HASH_W'(0);
  localparam logic [HASH_W-1:0] TAG_DELETED = HASH_W'(1);
  localparam logic [HASH_W-1:0] TAG_RSV_BIT = HASH_W'(2);

  localparam logic ST_STORED = 1'b0;
  localparam logic ST_FULL   = 1'b1;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [HASH_W-1:0] tag;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_t;

endpackage

@@ hw/rtl/hti_if.sv @@
// ----------------------------------------------------------------------------
// hti_if: valid/ready channels of the hash table insert block
// One channel carries insert requests, the other carries insert results.
// ----------------------------------------------------------------------------
interface hti_in_if import hti_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] key_hash;
  logic [KEY_W-1:0]  entry_key;
  logic [VAL_W-1:0]  entry_value;

  modport source (output valid, output key_hash, output entry_key, output entry_value,
                  input ready);
  modport sink   (input valid, input key_hash, input entry_key, input entry_value,
                  output ready);
endinterface

interface hti_out_if import hti_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              insert_status;
  logic [SLOT_W-1:0] slot_written;
  logic              replaced_existing;

  modport source (output valid, output insert_status, output slot_written,
                  output replaced_existing, input ready);
  modport sink   (input valid, input insert_status, input slot_written,
                  input replaced_existing, output ready);
endinterface

@@ hw/rtl/hti_ram.sv @@
// ----------------------------------------------------------------------------
// hti_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module hti_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/hti_cfg.sv @@
// ----------------------------------------------------------------------------
// hti_cfg: APB-style configuration register
// Holds the capacity register; writes complete in the access phase.
// ----------------------------------------------------------------------------
module hti_cfg import hti_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CAP_W-1:0] capacity
);

  logic [CAP_W-1:0] cap_r;
  logic             wr_cap;

  assign pready = 1'b1;
  assign wr_cap = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (wr_cap) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // Low address bits are ignored; registers are word aligned.
  assign prdata   = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_r} : 32'd0;
  assign capacity = cap_r;

endmodule

@@ hw/rtl/hti_probe.sv @@
// ----------------------------------------------------------------------------
// hti_probe: insert sequencer
// Clears the slot memory after reset, reduces the hash modulo the capacity,
// walks the triangular probe sequence and writes the chosen slot.
// ----------------------------------------------------------------------------
module hti_probe import hti_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CAP_W-1:0] capacity,
  hti_in_if.sink           in_chan,
  hti_out_if.source        out_chan,
  output logic             ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output slot_t            ram_wdata,
  output logic             ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  slot_t            ram_rdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_PROBE
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [HASH_W-1:0] tag_r, tag_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [HASH_W-1:0] dvd_r, dvd_nxt;
  logic [CAP_W-1:0]  rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [CAP_W-1:0]  idx_r, idx_nxt;
  logic              ov_r, ov_nxt;
  logic              st_r, st_nxt;
  logic [SLOT_W-1:0] sw_r, sw_nxt;
  logic              rep_r, rep_nxt;

  logic [CAP_W-1:0]  cap_eff;
  logic [CAP_W:0]    rem_step;
  logic [CAP_W:0]    pos_sum;
  logic [CAP_W:0]    pos_wrap;
  logic [CAP_W-1:0]  idx_inc;
  logic              slot_free;
  logic              slot_match;
  logic              hit;
  logic              exhausted;
  logic              out_free;

  // Capacity zero counts as one; anything past the table saturates.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_MIN;
    end else if (capacity > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = capacity;
    end
  end

  // Restoring remainder, DIV_BITS hash bits per cycle, most significant first.
  always_comb begin
    rem_step = {1'b0, rem_r};
    for (int k = 0; k < DIV_BITS; k++) begin
      rem_step = {rem_step[CAP_W-1:0], dvd_r[HASH_W-1-k]};
      if (rem_step >= {1'b0, cap_r}) begin
        rem_step = rem_step - {1'b0, cap_r};
      end
    end
  end

  assign slot_free  = ram_rdata.tag <= TAG_DELETED;
  assign slot_match = (ram_rdata.tag == tag_r) && (ram_rdata.key == key_r);
  assign hit        = slot_free || slot_match;
  assign idx_inc    = idx_r + CAP_W'(1);
  assign exhausted  = idx_inc == cap_r;
  assign pos_sum    = {{(CAP_W+1-ADDR_W){1'b0}}, pos_r} + {1'b0, idx_inc};
  assign pos_wrap   = (pos_sum >= {1'b0, cap_r}) ? pos_sum - {1'b0, cap_r} : pos_sum;
  assign out_free   = !ov_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    tag_nxt   = tag_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    cap_nxt   = cap_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_chan.ready;
    st_nxt    = st_r;
    sw_nxt    = sw_r;
    rep_nxt   = rep_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = '{tag: tag_r, key: key_r, value: val_r};
    ram_re    = 1'b0;
    ram_raddr = pos_r;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '{tag: TAG_EMPTY, key: '0, value: '0};
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          tag_nxt   = in_chan.key_hash | TAG_RSV_BIT;
          key_nxt   = in_chan.entry_key;
          val_nxt   = in_chan.entry_value;
          dvd_nxt   = in_chan.key_hash | TAG_RSV_BIT;
          cap_nxt   = cap_eff;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        dvd_nxt = dvd_r << DIV_BITS;
        rem_nxt = rem_step[CAP_W-1:0];
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_CYC - 1)) begin
          pos_nxt   = rem_step[ADDR_W-1:0];
          idx_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (hit || exhausted) begin
          // Hold the read data until the result register can take the result.
          if (out_free) begin
            ov_nxt    = 1'b1;
            st_nxt    = hit ? ST_STORED : ST_FULL;
            sw_nxt    = hit ? SLOT_W'(pos_r) : '0;
            rep_nxt   = hit && !slot_free;
            ram_we    = hit;
            state_nxt = S_IDLE;
          end
        end else begin
          pos_nxt   = pos_wrap[ADDR_W-1:0];
          idx_nxt   = idx_inc;
          ram_re    = 1'b1;
          ram_raddr = pos_wrap[ADDR_W-1:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    tag_r <= tag_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    cap_r <= cap_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    st_r  <= st_nxt;
    sw_r  <= sw_nxt;
    rep_r <= rep_nxt;
  end

  assign in_chan.ready              = state_r == S_IDLE;
  assign out_chan.valid             = ov_r;
  assign out_chan.insert_status     = st_r;
  assign out_chan.slot_written      = sw_r;
  assign out_chan.replaced_existing = rep_r;

endmodule

@@ hw/rtl/hash_table_insert_probe.sv @@
// ----------------------------------------------------------------------------
// hash_table_insert_probe: open-addressing hash table insert, triangular probing
// Top level: configuration register, slot memory and insert sequencer.
// ----------------------------------------------------------------------------
// Usage. Insert requests arrive on in_chan as a transfer of key_hash,
// entry_key and entry_value. Bit 1 of the hash is forced high so the empty
// and deleted tags stay reserved. Each request yields exactly one transfer on
// out_chan: insert_status (0 stored, 1 full), slot_written and
// replaced_existing.
// Sequence. The request is taken in idle, then the modulo unit runs (four
// remainder bits per cycle over the 32-bit hash), then the first slot read is
// issued, then the probes walk the table, each probe being one read of the slot
// memory, up to capacity probes; only the final probe can wait on the output.
// Only one insert is in flight; the next request is taken after the result
// of the current one has been loaded into the output register.
// Reset. The tag store is cleared by a pass that writes one slot per cycle over
// all 1024 slots, during which in_chan.ready stays low. Capacity resets to 1024.
// Stall. A result waits in the output register; a new request is taken while
// it waits, and that request holds at its final probe until the register frees.
// The user writes configuration via the APB port only while idle; not enforced.
// ----------------------------------------------------------------------------
module hash_table_insert_probe import hti_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hti_in_if.sink      in_chan,
  hti_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CAP_W-1:0]  capacity;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  slot_t             ram_rdata;

  // Capacity register behind the APB port.
  hti_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // Tag, key and value of every slot live in one word of this memory.
  hti_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH ($bits(slot_t))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: clearing pass, modulo, probe walk and result register.
  hti_probe u_probe (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

@@ hw/rtl/hti_checker.sv @@
// ----------------------------------------------------------------------------
// hti_checker: port-level assertions for the hash table insert block
// Watches the channels of the top level and is attached by a bind.
// ----------------------------------------------------------------------------
module hti_checker import hti_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_status,
  input logic [SLOT_W-1:0] out_slot,
  input logic              out_replaced
);

  // A pending result stays offered until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_slot) &&
                                $stable(out_replaced))
    else $error("result payload changed while stalled");

  // The clearing pass keeps requests out right after reset.
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request accepted during the clearing pass");

  // A full table reports no slot and no replacement.
  a_full_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_slot == '0) && !out_replaced)
    else $error("full result carries a slot or a replacement");

  // One insert at a time: the block is busy after taking a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while an insert is in flight");

endmodule

bind hash_table_insert_probe hti_checker u_hti_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_status   (out_chan.insert_status),
  .out_slot     (out_chan.slot_written),
  .out_replaced (out_chan.replaced_existing)
);
